>>> sv/ddfp_pkg.sv
// ----------------------------------------------------------------------------
// ddfp_pkg: shared types and constants of the decimal display formatter
// Character codes, configuration indexes and the conversion stage payload.
// ----------------------------------------------------------------------------
package ddfp_pkg;

	localparam int BIN_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int BITS_PER_STAGE = 8;
	localparam int NUM_STAGES = BIN_W / BITS_PER_STAGE;
	localparam int NUM_CHARS  = NUM_DIGITS + 1;
	localparam int CHAR_W     = 6;
	localparam int TDATA_OUT_W = ((NUM_CHARS * CHAR_W + 7) / 8) * 8;

	localparam logic [3:0] MAX_DIGITS = 4'd10;
	localparam logic [3:0] DIGITS_RESET = 4'd6;
	localparam logic [3:0] POINT_RESET  = 4'd0;

	localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
	localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

	// configuration register indexes
	localparam logic CFG_DIGITS = 1'b0;
	localparam logic CFG_POINT  = 1'b1;

	typedef logic [BCD_W-1:0] bcd_word_t;

	typedef struct packed {
		bcd_word_t        bcd;
		logic [BIN_W-1:0] bin;
	} conv_data_t;

	typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] char_row_t;

endpackage

>>> sv/decimal_display_formatter_point_top.sv
// ----------------------------------------------------------------------------
// decimal_display_formatter_point_top: value to fixed-width decimal display
// Four conversion stages feed a formatter and an output register.
// ----------------------------------------------------------------------------
// Path: the value passes the four conversion stage registers, then the output register, before m_tdata.
// Throughput: one item per cycle; each of the four conversion stages takes
// eight value bits, and every stage holds its item only while the one after
// it is full and stalled.
// Reset: arst_n clears all valid flags and loads digits_in_use = 6 and
// point_position = 0.
module decimal_display_formatter_point_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ddfp_pkg::BIN_W-1:0]          s_tdata,  // [31:0] value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ddfp_pkg::TDATA_OUT_W-1:0]    m_tdata,  // char_0..char_10, 6 bits each, zero pad
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [3:0]                          cfg_data
);

	logic [3:0] digits_q;
	logic [3:0] point_q;

	logic                 st_valid [ddfp_pkg::NUM_STAGES+1];
	logic                 st_ready [ddfp_pkg::NUM_STAGES+1];
	ddfp_pkg::conv_data_t st_data  [ddfp_pkg::NUM_STAGES+1];

	ddfp_pkg::char_row_t chars;
	ddfp_pkg::char_row_t chars_q;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= ddfp_pkg::DIGITS_RESET;
			point_q  <= ddfp_pkg::POINT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ddfp_pkg::CFG_DIGITS: digits_q <= cfg_data;
				ddfp_pkg::CFG_POINT:  point_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign st_valid[0]     = s_tvalid;
	assign st_data[0].bcd  = '0;
	assign st_data[0].bin  = s_tdata;
	assign s_tready        = st_ready[0];

	for (genvar g = 0; g < ddfp_pkg::NUM_STAGES; g++) begin : g_stage
		ddfp_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[g]),
			.in_ready  (st_ready[g]),
			.in_data   (st_data[g]),
			.out_valid (st_valid[g+1]),
			.out_ready (st_ready[g+1]),
			.out_data  (st_data[g+1])
		);
	end

	ddfp_format u_format (
		.bcd            (st_data[ddfp_pkg::NUM_STAGES].bcd),
		.digits_in_use  (digits_q),
		.point_position (point_q),
		.chars          (chars)
	);

	// output register: load when empty or when the held result transfers
	assign st_ready[ddfp_pkg::NUM_STAGES] = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_ready[ddfp_pkg::NUM_STAGES]) begin
			out_valid_q <= st_valid[ddfp_pkg::NUM_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (st_ready[ddfp_pkg::NUM_STAGES] && st_valid[ddfp_pkg::NUM_STAGES]) begin
			chars_q <= chars;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ddfp_pkg::TDATA_OUT_W - ddfp_pkg::NUM_CHARS * ddfp_pkg::CHAR_W){1'b0}},
		chars_q};

endmodule

>>> sv/ddfp_dabble_stage.sv
// ----------------------------------------------------------------------------
// ddfp_dabble_stage: one registered binary-to-BCD conversion stage
// Shifts eight binary bits into the BCD word with add-3 correction per digit.
// ----------------------------------------------------------------------------
module ddfp_dabble_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ddfp_pkg::conv_data_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ddfp_pkg::conv_data_t out_data
);

	logic                 valid_q;
	ddfp_pkg::conv_data_t data_q;
	ddfp_pkg::conv_data_t next_data;

	function automatic ddfp_pkg::conv_data_t dabble(input ddfp_pkg::conv_data_t d);
		ddfp_pkg::bcd_word_t        b;
		logic [ddfp_pkg::BIN_W-1:0] v;
		ddfp_pkg::conv_data_t       r;
		b = d.bcd;
		v = d.bin;
		for (int s = 0; s < ddfp_pkg::BITS_PER_STAGE; s++) begin
			for (int k = 0; k < ddfp_pkg::NUM_DIGITS; k++) begin
				if (b[4*k +: 4] >= 4'd5) begin
					b[4*k +: 4] = b[4*k +: 4] + 4'd3;
				end
			end
			b = {b[ddfp_pkg::BCD_W-2:0], v[ddfp_pkg::BIN_W-1]};
			v = {v[ddfp_pkg::BIN_W-2:0], 1'b0};
		end
		r.bcd = b;
		r.bin = v;
		return r;
	endfunction

	assign next_data = dabble(in_data);
	assign in_ready  = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> sv/ddfp_format.sv
// ----------------------------------------------------------------------------
// ddfp_format: BCD digits to display characters
// Clamps the digit count and point, places digits and point, blanks leading zeros.
// ----------------------------------------------------------------------------
module ddfp_format (
	input  ddfp_pkg::bcd_word_t bcd,
	input  logic [3:0]          digits_in_use,
	input  logic [3:0]          point_position,
	output ddfp_pkg::char_row_t chars
);

	function automatic logic [ddfp_pkg::CHAR_W-1:0] digit_char(
		input ddfp_pkg::bcd_word_t b,
		input logic [3:0]          idx
	);
		logic [3:0] d;
		d = 4'd0;
		for (int k = 0; k < ddfp_pkg::NUM_DIGITS; k++) begin
			if (idx == 4'(k)) begin
				d = b[4*k +: 4];
			end
		end
		return ddfp_pkg::CH_ZERO + {2'b00, d};
	endfunction

	logic [3:0]          len;
	logic [3:0]          pt;
	logic [3:0]          ip;
	ddfp_pkg::char_row_t raw;
	logic                run;

	always_comb begin
		if (digits_in_use == 4'd0) begin
			len = 4'd1;
		end else if (digits_in_use > ddfp_pkg::MAX_DIGITS) begin
			len = ddfp_pkg::MAX_DIGITS;
		end else begin
			len = digits_in_use;
		end
		if (point_position >= len) begin
			pt = len - 4'd1;
		end else begin
			pt = point_position;
		end
		ip = len - pt;
	end

	// place digits; the most significant shown digit is BCD digit len-1
	always_comb begin
		for (int p = 0; p < ddfp_pkg::NUM_CHARS; p++) begin
			raw[p] = '0;
			if (4'(p) <= len) begin
				if (pt == 4'd0) begin
					if (p == 0) begin
						raw[p] = ddfp_pkg::CH_ZERO;
					end else begin
						raw[p] = digit_char(bcd, len - 4'(p));
					end
				end else if (4'(p) < ip) begin
					raw[p] = digit_char(bcd, len - 4'd1 - 4'(p));
				end else if (4'(p) == ip) begin
					raw[p] = ddfp_pkg::CH_POINT;
				end else begin
					raw[p] = digit_char(bcd, len - 4'(p));
				end
			end
		end
	end

	// blank leading zeros, stop before the point and at the last character
	always_comb begin
		chars = raw;
		run   = 1'b1;
		for (int i = 0; i < ddfp_pkg::NUM_DIGITS; i++) begin
			if (run && (4'(i) < len) && (raw[i] == ddfp_pkg::CH_ZERO)
					&& (raw[i+1] != ddfp_pkg::CH_POINT)) begin
				chars[i] = ddfp_pkg::CH_SPACE;
			end else begin
				run = 1'b0;
			end
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for decimal_display_formatter_point_top
// Streams values through the formatter under a series of digit and point
// settings, predicts every display row, and compares each output transfer
// character by character against the oldest predicted row.
// ----------------------------------------------------------------------------
module tb;

	localparam int OUT_BITS      = ddfp_pkg::NUM_CHARS * ddfp_pkg::CHAR_W;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 62;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [ddfp_pkg::BIN_W-1:0]       s_tdata   = '0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [ddfp_pkg::TDATA_OUT_W-1:0] m_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic                             cfg_index = ddfp_pkg::CFG_DIGITS;
	logic [3:0]                       cfg_data  = '0;

	// settings the formatter holds right now
	logic [3:0] cur_digits = ddfp_pkg::DIGITS_RESET;
	logic [3:0] cur_point  = ddfp_pkg::POINT_RESET;

	logic [ddfp_pkg::BIN_W-1:0] values_to_send [$];
	ddfp_pkg::char_row_t        displays_due [$];

	int error_count = 0;
	int cycle_count = 0;
	int items_due   = 0;
	int burst_left  = 0;
	int gap_left    = 0;
	int stall_mode  = 0;
	int mode_left   = 0;
	int k;
	ddfp_pkg::char_row_t want;

	decimal_display_formatter_point_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Expected display row for one value under the given settings.
	function automatic ddfp_pkg::char_row_t format_display(
			logic [ddfp_pkg::BIN_W-1:0] value,
			logic [3:0] digits_reg, logic [3:0] point_reg);
		int unsigned len;
		int unsigned pt;
		int unsigned ip;
		int unsigned i;
		int unsigned dig [ddfp_pkg::NUM_DIGITS];
		logic [ddfp_pkg::BIN_W-1:0] v;
		logic blanking;
		ddfp_pkg::char_row_t row;
		len = digits_reg;
		if (len == 0)
			len = 1;
		if (len > ddfp_pkg::MAX_DIGITS)
			len = ddfp_pkg::MAX_DIGITS;
		pt = point_reg;
		if (pt >= len)
			pt = len - 1;
		v = value;
		for (i = 0; i < len; i++) begin
			dig[len - 1 - i] = v % 10;
			v = v / 10;
		end
		row = '0;
		if (pt == 0) begin
			row[0] = ddfp_pkg::CH_ZERO;
			for (i = 0; i < len; i++)
				row[i + 1] = ddfp_pkg::CH_ZERO + ddfp_pkg::CHAR_W'(dig[i]);
		end else begin
			ip = len - pt;
			for (i = 0; i < ip; i++)
				row[i] = ddfp_pkg::CH_ZERO + ddfp_pkg::CHAR_W'(dig[i]);
			row[ip] = ddfp_pkg::CH_POINT;
			for (i = ip; i < len; i++)
				row[i + 1] = ddfp_pkg::CH_ZERO + ddfp_pkg::CHAR_W'(dig[i]);
		end
		// blank leading zeros, keep the one in front of the point and the last digit
		blanking = 1'b1;
		for (i = 0; i < len; i++) begin
			if (blanking && row[i] == ddfp_pkg::CH_ZERO && row[i + 1] != ddfp_pkg::CH_POINT)
				row[i] = ddfp_pkg::CH_SPACE;
			else
				blanking = 1'b0;
		end
		return row;
	endfunction

	function automatic logic [ddfp_pkg::BIN_W-1:0] pick_value();
		longint unsigned scale;
		int n;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 99);
			2: return $urandom_range(0, 999999);
			3: begin
				scale = 1;
				n = $urandom_range(0, 9);
				repeat (n) scale = scale * 10;
				scale = scale * $urandom_range(0, (n == 9) ? 4 : 9);
				if ($urandom_range(0, 1) && scale != 0)
					scale = scale - 1;
				return ddfp_pkg::BIN_W'(scale);
			end
			default: return {4'($urandom_range(0, 15)), 28'(0)}
				| ddfp_pkg::BIN_W'($urandom_range(0, 9));
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic [3:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ddfp_pkg::CFG_DIGITS)
			cur_digits = data;
		else
			cur_point = data;
		cfg_valid <= 1'b0;
	endtask

	// Hold until every queued value has come back as a result.
	task automatic wait_idle();
		do @(posedge clk);
		while (items_due > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_values(input logic [ddfp_pkg::BIN_W-1:0] vals [$]);
		items_due += vals.size();
		foreach (vals[j])
			values_to_send.push_back(vals[j]);
		wait_idle();
	endtask

	// sender: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready)
				displays_due.push_back(format_display(s_tdata, cur_digits, cur_point));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (values_to_send.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= values_to_send.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern that switches between always ready, coin flip and sparse
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_mode = 0;
			mode_left  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				items_due--;
				if (displays_due.size() == 0) begin
					$error("unexpected result transfer: m_tdata %h", m_tdata);
					error_count++;
				end else begin
					want = displays_due.pop_front();
					for (k = 0; k < ddfp_pkg::NUM_CHARS; k++) begin
						if (m_tdata[k*ddfp_pkg::CHAR_W +: ddfp_pkg::CHAR_W] !== want[k]) begin
							$error("char_%0d: expected %0d, actual %0d",
								k, want[k], m_tdata[k*ddfp_pkg::CHAR_W +: ddfp_pkg::CHAR_W]);
							error_count++;
						end
					end
					if (m_tdata[ddfp_pkg::TDATA_OUT_W-1:OUT_BITS] !== '0) begin
						$error("pad: expected 0, actual %0d",
							m_tdata[ddfp_pkg::TDATA_OUT_W-1:OUT_BITS]);
						error_count++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(16, 128);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[decimal_display_formatter_point_top] ERROR");
			$finish;
		end
	end

	initial begin
		logic [ddfp_pkg::BIN_W-1:0] batch [$];
		logic [3:0] digits;
		logic [3:0] point;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings after reset: six digits, no point
		send_values('{0, 1, 10, 999999, 1000000, 32'hFFFF_FFFF, 100500});

		// widest display, point as far left as it goes
		write_reg(ddfp_pkg::CFG_DIGITS, 4'd10);
		write_reg(ddfp_pkg::CFG_POINT, 4'd9);
		send_values('{0, 32'hFFFF_FFFF, 1000000007});

		// zero just before the point stays
		write_reg(ddfp_pkg::CFG_DIGITS, 4'd4);
		write_reg(ddfp_pkg::CFG_POINT, 4'd3);
		send_values('{1234, 0, 5, 50, 12345});

		// one digit: point clamps away
		write_reg(ddfp_pkg::CFG_DIGITS, 4'd1);
		write_reg(ddfp_pkg::CFG_POINT, 4'd5);
		send_values('{0, 7, 19});

		// digit count zero acts as one
		write_reg(ddfp_pkg::CFG_DIGITS, 4'd0);
		write_reg(ddfp_pkg::CFG_POINT, 4'd0);
		send_values('{8, 0});

		// digit count and point both saturate
		write_reg(ddfp_pkg::CFG_DIGITS, 4'd15);
		write_reg(ddfp_pkg::CFG_POINT, 4'd15);
		send_values('{32'hFFFF_FFFF, 12});

		write_reg(ddfp_pkg::CFG_DIGITS, 4'd10);
		write_reg(ddfp_pkg::CFG_POINT, 4'd0);
		send_values('{32'hFFFF_FFFF, 9, 32'h8000_0000});

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			digits = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
			                                     : 4'($urandom_range(1, 10));
			case ($urandom_range(0, 3))
				0:       point = 4'd0;
				1:       point = (digits > 1) ? digits - 4'd1 : 4'd0;
				default: point = 4'($urandom_range(0, 15));
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(ddfp_pkg::CFG_POINT, point);
				write_reg(ddfp_pkg::CFG_DIGITS, digits);
			end else begin
				write_reg(ddfp_pkg::CFG_DIGITS, digits);
				write_reg(ddfp_pkg::CFG_POINT, point);
			end
			batch.delete();
			repeat (PHASE_ITEMS) batch.push_back(pick_value());
			send_values(batch);
		end

		if (error_count == 0)
			$display("[decimal_display_formatter_point_top] OK");
		else
			$display("[decimal_display_formatter_point_top] ERROR");
		$finish;
	end

endmodule

>>> sim.f
sv/ddfp_pkg.sv
sv/ddfp_dabble_stage.sv
sv/ddfp_format.sv
sv/decimal_display_formatter_point_top.sv
tb/sv/tb.sv
